// ===== rtl/bdt_pkg.sv =====
// Shared types and constants for the button debounce/timestamp block.
// Used by bdt_regs.sv and button_debounce_timestamp_unit.sv.
package bdt_pkg;

  localparam int MS_BITS  = 10;
  localparam int THR_BITS = 20;  // 1023 ms * 1000 fits in 20 bits
  localparam logic [THR_BITS-1:0] US_PER_MS = THR_BITS'(1000);

  localparam int APB_ADDR_BITS = 4;
  localparam int APB_DATA_BITS = 32;

  typedef enum logic [1:0] {
    REG_ACTIVE_LOW = 2'd0,
    REG_CONFIRM_MS = 2'd1,
    REG_GLITCH_MS  = 2'd2,
    REG_RELEASE_MS = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    EV_NONE    = 2'd0,
    EV_PRESS   = 2'd1,
    EV_RELEASE = 2'd2
  } event_t;

  typedef enum logic {
    FUNC_EDGE = 1'b0,
    FUNC_POLL = 1'b1
  } func_t;

  typedef struct packed {
    logic                active_low;
    logic [MS_BITS-1:0]  confirm_ms;
    logic [MS_BITS-1:0]  glitch_ms;
    logic [MS_BITS-1:0]  release_ms;
  } cfg_t;

  function automatic logic [THR_BITS-1:0] ms_to_us(input logic [MS_BITS-1:0] ms);
    return THR_BITS'(ms) * US_PER_MS;
  endfunction

endpackage

// ===== rtl/bdt_if.sv =====
// Valid/ready channel interfaces for debounce input words and result words.
// Depends on nothing; width follows the TIME_BITS parameter.
interface bdt_in_if #(parameter int TIME_BITS = 48);
  logic                 valid;
  logic                 ready;
  logic                 func;
  logic [TIME_BITS-1:0] time_us;
  logic                 pin_level;

  modport source (output valid, output func, output time_us, output pin_level, input ready);
  modport sink   (input valid, input func, input time_us, input pin_level, output ready);
endinterface

interface bdt_out_if #(parameter int TIME_BITS = 48);
  logic                 valid;
  logic                 ready;
  logic [1:0]           event_res;
  logic [TIME_BITS-1:0] event_time_us;
  logic                 button_down;

  modport source (output valid, output event_res, output event_time_us,
                  output button_down, input ready);
  modport sink   (input valid, input event_res, input event_time_us,
                  input button_down, output ready);
endinterface

// ===== rtl/bdt_regs.sv =====
// APB-style configuration registers of the debounce block.
// Depends on bdt_pkg.
module bdt_regs (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [bdt_pkg::APB_ADDR_BITS-1:0]   paddr,
  input  logic [bdt_pkg::APB_DATA_BITS-1:0]   pwdata,
  output logic [bdt_pkg::APB_DATA_BITS-1:0]   prdata,
  output logic                                pready,
  output bdt_pkg::cfg_t                       cfg
);
  import bdt_pkg::*;

  reg_idx_t idx;
  logic     wr;

  assign idx    = reg_idx_t'(paddr[3:2]);
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.active_low <= 1'b1;
      cfg.confirm_ms <= MS_BITS'(20);
      cfg.glitch_ms  <= MS_BITS'(50);
      cfg.release_ms <= MS_BITS'(30);
    end else if (wr) begin
      unique case (idx)
        REG_ACTIVE_LOW: cfg.active_low <= pwdata[0];
        REG_CONFIRM_MS: cfg.confirm_ms <= pwdata[MS_BITS-1:0];
        REG_GLITCH_MS:  cfg.glitch_ms  <= pwdata[MS_BITS-1:0];
        REG_RELEASE_MS: cfg.release_ms <= pwdata[MS_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_ACTIVE_LOW: prdata = APB_DATA_BITS'(cfg.active_low);
      REG_CONFIRM_MS: prdata = APB_DATA_BITS'(cfg.confirm_ms);
      REG_GLITCH_MS:  prdata = APB_DATA_BITS'(cfg.glitch_ms);
      REG_RELEASE_MS: prdata = APB_DATA_BITS'(cfg.release_ms);
      default:        prdata = '0;
    endcase
  end

endmodule

// ===== rtl/button_debounce_timestamp_unit.sv =====
// Top level of the push-button debouncer with press/release timestamps.
// Depends on bdt_pkg, bdt_if (bdt_in_if, bdt_out_if) and bdt_regs.
//
// Usage:
//   item_in carries one word per edge or poll: func (0 edge, 1 poll),
//   time_us (free-running, wraps) and pin_level (polls only).
//   result_out returns exactly one word per input word: event_res
//   (none/press/release), event_time_us and the debounced button_down.
//   Registers active_low, confirm_ms, glitch_ms and release_ms sit on the
//   APB port at byte addresses 0, 4, 8 and 12; pready is always high.
// Timing:
//   A word is captured in an input register, the state update runs as
//   compares against the registered state, and the result lands in an
//   output register, which loads only when it is empty or result_out drains.
//   One word per cycle is accepted as long as result_out drains.
// Reset (rst, synchronous): released, no edge pending, registers at defaults.
// Stall: when result_out.ready is low the output register holds its word,
//   the input register fills, and item_in.ready drops until space frees up.
module button_debounce_timestamp_unit #(
  parameter int TIME_BITS = 48
) (
  input  logic                              clk,
  input  logic                              rst,
  bdt_in_if.sink                            item_in,
  bdt_out_if.source                         result_out,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [bdt_pkg::APB_ADDR_BITS-1:0] paddr,
  input  logic [bdt_pkg::APB_DATA_BITS-1:0] pwdata,
  output logic [bdt_pkg::APB_DATA_BITS-1:0] prdata,
  output logic                              pready
);
  import bdt_pkg::*;

  cfg_t cfg;

  bdt_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // input register
  logic                 s1_valid;
  func_t                s1_func;
  logic [TIME_BITS-1:0] s1_time;
  logic                 s1_pin;

  // result register
  logic                 res_valid;
  event_t               res_event;
  logic [TIME_BITS-1:0] res_time;
  logic                 res_down;

  // debounce state
  logic [TIME_BITS-1:0] edge_time, edge_time_next;
  logic                 edge_pending, edge_pending_next;
  logic                 held, held_next;
  logic [TIME_BITS-1:0] release_start, release_start_next;
  logic                 release_timing, release_timing_next;

  logic                 adv;
  logic                 in_fire;
  event_t               ev;
  logic [TIME_BITS-1:0] ts;
  logic                 pressed;
  logic [TIME_BITS-1:0] edge_age;
  logic [TIME_BITS-1:0] rel_age;
  logic [THR_BITS-1:0]  confirm_us, glitch_us, release_us;

  assign adv           = s1_valid && (!res_valid || result_out.ready);
  assign item_in.ready = !s1_valid || adv;
  assign in_fire       = item_in.valid && item_in.ready;

  assign confirm_us = ms_to_us(cfg.confirm_ms);
  assign glitch_us  = ms_to_us(cfg.glitch_ms);
  assign release_us = ms_to_us(cfg.release_ms);

  assign pressed  = cfg.active_low ? !s1_pin : s1_pin;
  assign edge_age = s1_time - edge_time;
  // a fresh release window starts at this poll, so its age is zero
  assign rel_age  = release_timing ? (s1_time - release_start) : '0;

  always_comb begin
    ev                  = EV_NONE;
    ts                  = '0;
    edge_time_next      = edge_time;
    edge_pending_next   = edge_pending;
    held_next           = held;
    release_start_next  = release_start;
    release_timing_next = release_timing;
    unique case (s1_func)
      FUNC_EDGE: begin
        if (!edge_pending) begin
          edge_time_next    = s1_time;
          edge_pending_next = 1'b1;
        end
      end
      FUNC_POLL: begin
        if (!held) begin
          if (edge_pending && edge_age >= TIME_BITS'(confirm_us)) begin
            if (pressed) begin
              held_next           = 1'b1;
              release_timing_next = 1'b0;
              ev                  = EV_PRESS;
              ts                  = edge_time;
            end else if (edge_age > TIME_BITS'(glitch_us)) begin
              edge_pending_next = 1'b0;
            end
          end
        end else if (pressed) begin
          release_timing_next = 1'b0;
        end else begin
          if (!release_timing) begin
            release_start_next  = s1_time;
            release_timing_next = 1'b1;
          end
          if (rel_age >= TIME_BITS'(release_us)) begin
            held_next           = 1'b0;
            edge_pending_next   = 1'b0;
            release_timing_next = 1'b0;
            ev                  = EV_RELEASE;
            ts                  = s1_time;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid       <= 1'b0;
      res_valid      <= 1'b0;
      edge_pending   <= 1'b0;
      held           <= 1'b0;
      release_timing <= 1'b0;
      edge_time      <= '0;
      release_start  <= '0;
    end else begin
      if (item_in.ready) begin
        s1_valid <= item_in.valid;
      end
      if (adv) begin
        res_valid      <= 1'b1;
        edge_time      <= edge_time_next;
        edge_pending   <= edge_pending_next;
        held           <= held_next;
        release_start  <= release_start_next;
        release_timing <= release_timing_next;
      end else if (result_out.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_func <= func_t'(item_in.func);
      s1_time <= item_in.time_us;
      s1_pin  <= item_in.pin_level;
    end
    if (adv) begin
      res_event <= ev;
      res_time  <= ts;
      res_down  <= held_next;
    end
  end

  assign result_out.valid         = res_valid;
  assign result_out.event_res     = res_event;
  assign result_out.event_time_us = res_time;
  assign result_out.button_down   = res_down;

  a_press_down: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_event == EV_PRESS |-> res_down)
    else $error("press result without button down");

  a_release_up: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_event == EV_RELEASE |-> !res_down)
    else $error("release result with button still down");

  a_none_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_event == EV_NONE |-> res_time == '0)
    else $error("no-event result carries a nonzero time");

  a_held_rise: assert property (@(posedge clk) disable iff (rst)
    $rose(held) |-> res_valid && res_event == EV_PRESS)
    else $error("button went down without a press result");

  a_no_time_when_held: assert property (@(posedge clk) disable iff (rst)
    !held |-> !release_timing)
    else $error("release window open while button is up");

endmodule
